// ===== design/biq_pkg.sv =====
// Shared constants and types for the biquad filter.
package biq_pkg;

    localparam int COEF_BITS = 32;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FF_COEF0 = 3'd0,
        REG_FF_COEF1 = 3'd1,
        REG_FF_COEF2 = 3'd2,
        REG_FB_COEF1 = 3'd3,
        REG_FB_COEF2 = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic load;
        logic clear;
    } cell_ctrl_t;

endpackage

// ===== design/biq_if.sv =====
// Stream interfaces for the input and output sample channels.
interface biq_in_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          restart;

    modport source (output valid, output sample_in, output restart, input ready);
    modport sink   (input valid, input sample_in, input restart, output ready);
endinterface

interface biq_out_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          clipped;

    modport source (output valid, output sample_out, output clipped, input ready);
    modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

// ===== design/biq_tap_cell.sv =====
// One tap of the filter: a history register, its coefficient product and a partial sum.
module biq_tap_cell #(
    parameter int SAMPLE_BITS = 24,
    parameter int ACC_BITS    = 59,
    parameter bit SUBTRACT    = 1'b0
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  biq_pkg::cell_ctrl_t                  ctrl,
    input  logic signed [biq_pkg::COEF_BITS-1:0] coef,
    input  logic signed [SAMPLE_BITS-1:0]        tap_in,
    output logic signed [SAMPLE_BITS-1:0]        tap_out,
    input  logic signed [ACC_BITS-1:0]           sum_in,
    output logic signed [ACC_BITS-1:0]           sum_out
);
    import biq_pkg::*;

    localparam int PROD_BITS = COEF_BITS + SAMPLE_BITS;

    logic signed [SAMPLE_BITS-1:0] tap_reg;
    logic signed [SAMPLE_BITS-1:0] operand;
    logic signed [PROD_BITS-1:0]   prod;

    // A restart makes the held history read as zero, both for the product
    // and for the value handed on to the next cell.
    assign operand = ctrl.clear ? '0 : tap_reg;
    assign tap_out = operand;
    assign prod    = coef * operand;

    always_comb
    begin
        if (SUBTRACT)
        begin
            sum_out = sum_in - ACC_BITS'(prod);
        end
        else
        begin
            sum_out = sum_in + ACC_BITS'(prod);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg <= '0;
        end
        else if (ctrl.load)
        begin
            tap_reg <= tap_in;
        end
    end

endmodule

// ===== design/biq_round_sat.sv =====
// Rounds the wide sum to nearest and saturates it to the sample range.
module biq_round_sat #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 24,
    parameter int ACC_BITS       = 59
) (
    input  logic signed [ACC_BITS-1:0]    acc,
    output logic signed [SAMPLE_BITS-1:0] result,
    output logic                          clipped
);
    localparam int Q_BITS = ACC_BITS - COEF_FRAC_BITS;
    localparam logic signed [ACC_BITS-1:0] HALF = ACC_BITS'(1) << (COEF_FRAC_BITS - 1);
    localparam logic [SAMPLE_BITS-1:0] MAX_VAL = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] MIN_VAL = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [ACC_BITS-1:0] rounded;
    logic signed [Q_BITS-1:0]   quot;
    logic                       in_range;

    assign rounded = acc + HALF;
    assign quot    = Q_BITS'(rounded >>> COEF_FRAC_BITS);

    // The value fits when all bits from the sample sign bit upward agree.
    assign in_range = (&quot[Q_BITS-1:SAMPLE_BITS-1]) || !(|quot[Q_BITS-1:SAMPLE_BITS-1]);
    assign clipped  = !in_range;

    always_comb
    begin
        if (in_range)
        begin
            result = quot[SAMPLE_BITS-1:0];
        end
        else if (quot[Q_BITS-1])
        begin
            result = MIN_VAL;
        end
        else
        begin
            result = MAX_VAL;
        end
    end

endmodule

// ===== design/biquad_iir_filter.sv =====
// Top level of the direct form I biquad filter with its coefficient registers.
//
//   channel  | direction | handshake     | payload
//   ---------+-----------+---------------+---------------------------------
//   in_ch    | sink      | valid / ready | sample_in, restart
//   out_ch   | source    | valid / ready | sample_out, clipped
//   cfg      | write     | cfg_we        | cfg_idx, cfg_data
//
// One sample per cycle sustained while out_ch is ready; a sample passes the input
// stage and the output register before it appears on out_ch. The output feedback
// loop is combinational: the five tap products, their sum, rounding and saturation
// close through the y1 tap cell register. Reset zeroes the history and loads the
// default coefficients. A stalled output holds one result, and one more sample
// waits in the input stage before in_ch.ready drops.
module biquad_iir_filter #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    biq_in_if.sink                            in_ch,
    biq_out_if.source                         out_ch,
    input  logic                              cfg_we,
    input  logic [biq_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  logic [biq_pkg::COEF_BITS-1:0]     cfg_data
);
    import biq_pkg::*;

    localparam int ACC_BITS = COEF_BITS + SAMPLE_BITS + 3;
    localparam int NUM_TAPS = 5;
    localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << COEF_FRAC_BITS;
    localparam logic [SAMPLE_BITS-1:0] MAX_VAL = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] MIN_VAL = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [COEF_BITS-1:0] coef_reg [NUM_TAPS];

    logic                          stage_vld_reg;
    logic                          restart_reg;
    logic                          out_vld_reg;
    logic signed [SAMPLE_BITS-1:0] out_data_reg;
    logic                          clip_reg;

    logic in_accept;
    logic advance;

    cell_ctrl_t head_ctrl;
    cell_ctrl_t hist_ctrl;

    logic signed [SAMPLE_BITS-1:0] tap_link [NUM_TAPS];
    logic signed [ACC_BITS-1:0]    sum_link [NUM_TAPS];
    logic signed [SAMPLE_BITS-1:0] y_val;
    logic                          y_clip;

    assign advance      = stage_vld_reg && (!out_vld_reg || out_ch.ready);
    assign in_ch.ready  = !stage_vld_reg || advance;
    assign in_accept    = in_ch.valid && in_ch.ready;

    assign head_ctrl = '{load: in_accept, clear: 1'b0};
    assign hist_ctrl = '{load: advance, clear: restart_reg};

    // Coefficient registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg[REG_FF_COEF0] <= COEF_ONE;
            coef_reg[REG_FF_COEF1] <= '0;
            coef_reg[REG_FF_COEF2] <= '0;
            coef_reg[REG_FB_COEF1] <= '0;
            coef_reg[REG_FB_COEF2] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_FF_COEF0: coef_reg[REG_FF_COEF0] <= cfg_data;
                REG_FF_COEF1: coef_reg[REG_FF_COEF1] <= cfg_data;
                REG_FF_COEF2: coef_reg[REG_FF_COEF2] <= cfg_data;
                REG_FB_COEF1: coef_reg[REG_FB_COEF1] <= cfg_data;
                REG_FB_COEF2: coef_reg[REG_FB_COEF2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Feedforward cells: current sample, x1, x2.
    biq_tap_cell #(.SAMPLE_BITS(SAMPLE_BITS), .ACC_BITS(ACC_BITS), .SUBTRACT(1'b0)) u_cell_x0 (
        .clk(clk), .rst_n(rst_n), .ctrl(head_ctrl), .coef(coef_reg[REG_FF_COEF0]),
        .tap_in(in_ch.sample_in), .tap_out(tap_link[0]),
        .sum_in('0), .sum_out(sum_link[0])
    );

    biq_tap_cell #(.SAMPLE_BITS(SAMPLE_BITS), .ACC_BITS(ACC_BITS), .SUBTRACT(1'b0)) u_cell_x1 (
        .clk(clk), .rst_n(rst_n), .ctrl(hist_ctrl), .coef(coef_reg[REG_FF_COEF1]),
        .tap_in(tap_link[0]), .tap_out(tap_link[1]),
        .sum_in(sum_link[0]), .sum_out(sum_link[1])
    );

    biq_tap_cell #(.SAMPLE_BITS(SAMPLE_BITS), .ACC_BITS(ACC_BITS), .SUBTRACT(1'b0)) u_cell_x2 (
        .clk(clk), .rst_n(rst_n), .ctrl(hist_ctrl), .coef(coef_reg[REG_FF_COEF2]),
        .tap_in(tap_link[1]), .tap_out(tap_link[2]),
        .sum_in(sum_link[1]), .sum_out(sum_link[2])
    );

    // Feedback cells: y1 takes the new output, y2 takes the old y1.
    biq_tap_cell #(.SAMPLE_BITS(SAMPLE_BITS), .ACC_BITS(ACC_BITS), .SUBTRACT(1'b1)) u_cell_y1 (
        .clk(clk), .rst_n(rst_n), .ctrl(hist_ctrl), .coef(coef_reg[REG_FB_COEF1]),
        .tap_in(y_val), .tap_out(tap_link[3]),
        .sum_in(sum_link[2]), .sum_out(sum_link[3])
    );

    biq_tap_cell #(.SAMPLE_BITS(SAMPLE_BITS), .ACC_BITS(ACC_BITS), .SUBTRACT(1'b1)) u_cell_y2 (
        .clk(clk), .rst_n(rst_n), .ctrl(hist_ctrl), .coef(coef_reg[REG_FB_COEF2]),
        .tap_in(tap_link[3]), .tap_out(tap_link[4]),
        .sum_in(sum_link[3]), .sum_out(sum_link[4])
    );

    biq_round_sat #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .COEF_FRAC_BITS(COEF_FRAC_BITS),
        .ACC_BITS(ACC_BITS)
    ) u_round_sat (
        .acc(sum_link[4]),
        .result(y_val),
        .clipped(y_clip)
    );

    // Input stage flag and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_vld_reg <= 1'b0;
            restart_reg   <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                stage_vld_reg <= 1'b1;
                restart_reg   <= in_ch.restart;
            end
            else if (advance)
            begin
                stage_vld_reg <= 1'b0;
            end

            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= y_val;
            clip_reg     <= y_clip;
        end
    end

    assign out_ch.valid      = out_vld_reg;
    assign out_ch.sample_out = out_data_reg;
    assign out_ch.clipped    = clip_reg;

    a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !stage_vld_reg |-> in_ch.ready)
        else $error("input not ready with an empty stage");

    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_vld_reg)
        else $error("computed sample did not reach the output register");

    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        stage_vld_reg && out_vld_reg && !out_ch.ready |-> !in_ch.ready)
        else $error("input taken while both stages are full");

    a_clip_is_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && clip_reg |-> (out_data_reg == MAX_VAL || out_data_reg == MIN_VAL))
        else $error("clipped result is not a range limit");

endmodule

// ===== verif/biquad_iir_filter_tb.sv =====
// Self-checking testbench for the biquad filter: directed corners, random phases, prediction.
`timescale 1ns / 1ps

module biquad_iir_filter_tb;

    import biq_pkg::*;

    localparam int SAMPLE_W      = 24;
    localparam int FRAC_W        = 24;
    localparam int NUM_COEF_REGS = 5;
    localparam int MAX_GAP       = 6;
    localparam int HOLD_CYCLES   = 80;
    localparam int DRAIN_CYCLES  = 6;
    localparam int END_CYCLES    = 10;
    localparam int PHASE_ITEMS   = 75;

    localparam logic signed [SAMPLE_W-1:0]  SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0]  SAMPLE_MIN = 24'sh800000;
    localparam logic signed [COEF_BITS-1:0] COEF_MAX   = 32'sh7FFFFFFF;
    localparam logic signed [COEF_BITS-1:0] COEF_MIN   = 32'sh80000000;
    localparam logic signed [COEF_BITS-1:0] COEF_ONE   = 32'sh01000000;
    localparam logic signed [COEF_BITS-1:0] COEF_HALF  = 32'sh00800000;

    // Kinds of coefficient sets used by the random phases.
    localparam int KIND_FULL    = 0;
    localparam int KIND_MODEST  = 1;
    localparam int KIND_EXTREME = 2;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       restart;
    } sample_item_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       clipped;
    } filter_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [COEF_BITS-1:0]  cfg_data;

    biq_in_if  #(.SAMPLE_BITS(SAMPLE_W)) in_ch ();
    biq_out_if #(.SAMPLE_BITS(SAMPLE_W)) out_ch ();

    biquad_iir_filter #(
        .SAMPLE_BITS    (SAMPLE_W),
        .COEF_FRAC_BITS (FRAC_W)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    // Predictor state: coefficient copies and the direct form I history.
    logic signed [COEF_BITS-1:0] coef_reg [NUM_COEF_REGS];
    logic signed [SAMPLE_W-1:0]  hist_x1, hist_x2, hist_y1, hist_y2;

    sample_item_t   pending_samples [$];
    filter_result_t expected_out [$];

    int           err_count;
    int           in_gap_left;
    int           out_stall_left;
    int           hold_left;
    int           hold_requests;
    int           hold_served;
    bit           in_gaps_on;
    bit           out_gaps_on;
    sample_item_t next_item;
    filter_result_t exp_res;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic filter_result_t filter_sample(input logic signed [SAMPLE_W-1:0] x,
                                                     input logic clear_hist);
        longint         acc;
        longint         q;
        filter_result_t r;
        if (clear_hist)
        begin
            hist_x1 = '0;
            hist_x2 = '0;
            hist_y1 = '0;
            hist_y2 = '0;
        end
        acc = longint'(coef_reg[REG_FF_COEF0]) * longint'(x)
            + longint'(coef_reg[REG_FF_COEF1]) * longint'(hist_x1)
            + longint'(coef_reg[REG_FF_COEF2]) * longint'(hist_x2)
            - longint'(coef_reg[REG_FB_COEF1]) * longint'(hist_y1)
            - longint'(coef_reg[REG_FB_COEF2]) * longint'(hist_y2);
        // Round half toward plus infinity, then drop the fraction bits.
        acc = acc + (longint'(1) <<< (FRAC_W - 1));
        q = acc >>> FRAC_W;
        r.clipped = 1'b1;
        if (q > longint'(SAMPLE_MAX))
        begin
            r.sample_out = SAMPLE_MAX;
        end
        else if (q < longint'(SAMPLE_MIN))
        begin
            r.sample_out = SAMPLE_MIN;
        end
        else
        begin
            r.sample_out = q[SAMPLE_W-1:0];
            r.clipped = 1'b0;
        end
        hist_x2 = hist_x1;
        hist_x1 = x;
        hist_y2 = hist_y1;
        hist_y1 = r.sample_out;
        return r;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        int v;
        case ($urandom_range(0, 4))
            0: v = $urandom;
            1: v = int'($urandom_range(0, 4000)) - 2000;
            2: v = $urandom_range(0, 1) ? int'(SAMPLE_MAX) : int'(SAMPLE_MIN);
            default: v = int'($urandom_range(0, 1 << 20)) - (1 << 19);
        endcase
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic logic signed [COEF_BITS-1:0] rand_coef(input int kind);
        int v;
        case (kind)
            KIND_FULL:   v = $urandom;
            KIND_MODEST: v = int'($urandom_range(0, 1 << 26)) - (1 << 25);
            default:
            begin
                case ($urandom_range(0, 4))
                    0: v = COEF_MAX;
                    1: v = COEF_MIN;
                    2: v = COEF_ONE;
                    3: v = -COEF_ONE;
                    default: v = 0;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic write_coef(input logic [CFG_IDX_W-1:0] idx,
                              input logic [COEF_BITS-1:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        // Indexes past the last register are ignored by the block.
        if (idx < NUM_COEF_REGS)
        begin
            coef_reg[idx] = val;
        end
    endtask

    task automatic load_coefs(input int kind);
        for (int i = 0; i < NUM_COEF_REGS; i++)
        begin
            write_coef(i[CFG_IDX_W-1:0], rand_coef(kind));
        end
        write_coef(CFG_IDX_W'($urandom_range(NUM_COEF_REGS, (1 << CFG_IDX_W) - 1)), $urandom);
    endtask

    task automatic push_item(input logic signed [SAMPLE_W-1:0] s, input logic rs);
        sample_item_t it;
        it.sample  = s;
        it.restart = rs;
        pending_samples.insert(pending_samples.size(), it);
    endtask

    task automatic wait_drain();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || in_ch.valid || expected_out.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic run_random_phase(input int kind, input bit in_on, input bit out_on,
                                    input bit with_hold);
        load_coefs(kind);
        @(negedge clk);
        in_gaps_on  = in_on;
        out_gaps_on = out_on;
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            push_item(rand_sample(), $urandom_range(0, 15) == 0);
        end
        if (with_hold)
        begin
            // The receiver stops while the sender keeps offering samples.
            repeat (8) @(negedge clk);
            hold_requests++;
        end
        wait_drain();
    endtask

    // Sender: presents queued samples and predicts each one as it is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid     <= 1'b0;
            in_ch.sample_in <= '0;
            in_ch.restart   <= 1'b0;
            in_gap_left      = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                expected_out.insert(expected_out.size(),
                                    filter_sample(in_ch.sample_in, in_ch.restart));
            end
            if (!(in_ch.valid && !in_ch.ready))
            begin
                if (in_gap_left > 0)
                begin
                    in_gap_left--;
                    in_ch.valid <= 1'b0;
                end
                else if (pending_samples.size() != 0)
                begin
                    next_item = pending_samples.pop_front();
                    in_ch.valid     <= 1'b1;
                    in_ch.sample_in <= next_item.sample;
                    in_ch.restart   <= next_item.restart;
                    in_gap_left = in_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks every output transaction against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready  <= 1'b0;
            out_stall_left = 0;
            hold_left      = 0;
            hold_served    = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_out.size() == 0)
                begin
                    $display("%0t: result with nothing expected: sample_out %0d clipped %0b",
                             $time, out_ch.sample_out, out_ch.clipped);
                    err_count++;
                end
                else
                begin
                    exp_res = expected_out.pop_front();
                    if (out_ch.sample_out !== exp_res.sample_out)
                    begin
                        $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                                 $time, exp_res.sample_out, out_ch.sample_out);
                        err_count++;
                    end
                    if (out_ch.clipped !== exp_res.clipped)
                    begin
                        $display("%0t: clipped mismatch: expected %0b, actual %0b",
                                 $time, exp_res.clipped, out_ch.clipped);
                        err_count++;
                    end
                end
                out_stall_left = out_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (hold_requests != hold_served)
            begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (out_stall_left > 0)
            begin
                out_stall_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = '0;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.sample_in = '0;
        in_ch.restart   = 1'b0;
        out_ch.ready    = 1'b0;
        err_count       = 0;
        hold_requests   = 0;
        in_gaps_on      = 1'b0;
        out_gaps_on     = 1'b0;
        coef_reg[REG_FF_COEF0] = COEF_ONE;
        coef_reg[REG_FF_COEF1] = '0;
        coef_reg[REG_FF_COEF2] = '0;
        coef_reg[REG_FB_COEF1] = '0;
        coef_reg[REG_FB_COEF2] = '0;
        hist_x1 = '0;
        hist_x2 = '0;
        hist_y1 = '0;
        hist_y2 = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset coefficients pass the input through unchanged.
        @(negedge clk);
        push_item(SAMPLE_MAX, 1'b0);
        push_item(SAMPLE_MIN, 1'b0);
        push_item('0, 1'b0);
        push_item(-24'sd1, 1'b0);
        push_item(24'sd1, 1'b1);
        push_item(24'sh555555, 1'b0);
        push_item(24'shAAAAAA, 1'b0);
        wait_drain();

        // Extreme coefficients drive the sum far past both rails.
        write_coef(REG_FF_COEF0, COEF_MAX);
        write_coef(REG_FF_COEF1, COEF_MIN);
        write_coef(REG_FF_COEF2, COEF_MAX);
        write_coef(REG_FB_COEF1, COEF_MIN);
        write_coef(REG_FB_COEF2, COEF_MAX);
        for (int i = NUM_COEF_REGS; i < (1 << CFG_IDX_W); i++)
        begin
            write_coef(i[CFG_IDX_W-1:0], 32'h12345678);
        end
        @(negedge clk);
        push_item(SAMPLE_MAX, 1'b1);
        push_item(SAMPLE_MAX, 1'b0);
        push_item(SAMPLE_MIN, 1'b0);
        push_item(SAMPLE_MIN, 1'b0);
        push_item(24'sd1, 1'b0);
        push_item('0, 1'b1);
        wait_drain();

        // A gain of one half puts odd inputs exactly on a rounding tie.
        write_coef(REG_FF_COEF0, COEF_HALF);
        write_coef(REG_FF_COEF1, '0);
        write_coef(REG_FF_COEF2, '0);
        write_coef(REG_FB_COEF1, '0);
        write_coef(REG_FB_COEF2, '0);
        @(negedge clk);
        push_item(24'sd1, 1'b1);
        push_item(-24'sd1, 1'b0);
        push_item(24'sd3, 1'b0);
        push_item(-24'sd3, 1'b0);
        wait_drain();

        run_random_phase(KIND_MODEST,  1'b1, 1'b1, 1'b0);
        run_random_phase(KIND_MODEST,  1'b0, 1'b0, 1'b1);
        run_random_phase(KIND_FULL,    1'b1, 1'b0, 1'b0);
        run_random_phase(KIND_EXTREME, 1'b0, 1'b1, 1'b0);
        run_random_phase(KIND_MODEST,  1'b1, 1'b1, 1'b1);
        run_random_phase(KIND_EXTREME, 1'b1, 1'b1, 1'b0);

        repeat (END_CYCLES) @(posedge clk);
        if (err_count == 0)
        begin
            $display("biquad_iir_filter_tb passed");
        end
        else
        begin
            $display("biquad_iir_filter_tb failed");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("biquad_iir_filter_tb failed");
        $finish;
    end

endmodule
